// File: rtl/psc_pkg.sv
// Shared types and constants for the point set centroid / bounding box block.
`timescale 1ns / 1ps
package psc_pkg;

	// capacity of one point set
	localparam int MAX_POINTS = 32;
	localparam int CNT_W      = 6;
	// shared adder width: covers 16-bit signed points against 17-bit box edges
	localparam int ALU_W      = 20;
	// restoring divider: dividend bits, one quotient bit per step
	localparam int DIV_W      = 17;
	localparam int STEP_W     = $clog2(DIV_W);
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

	typedef struct packed {
		logic signed [15:0] pt_x;
		logic signed [15:0] pt_y;
		logic               last_point;
	} in_item_t;

	typedef struct packed {
		logic [10:0] mean_x;
		logic [10:0] mean_y;
		logic [15:0] span_w;
		logic [15:0] span_h;
		logic [5:0]  outside_count;
		logic [5:0]  point_count;
		logic [8:0]  outside_ratio;
		logic        overflow;
	} out_item_t;

	typedef struct packed {
		logic [10:0] left;
		logic [10:0] top;
		logic [10:0] width;
		logic [10:0] height;
	} box_cfg_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t                  op;
		logic signed [ALU_W-1:0] a;
		logic signed [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic signed [ALU_W-1:0] res;
		logic                    neg;
	} alu_rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MINX,
		ST_MAXX,
		ST_MINY,
		ST_MAXY,
		ST_SUMX,
		ST_SUMY,
		ST_BL,
		ST_EDGX,
		ST_BR,
		ST_BT,
		ST_EDGY,
		ST_BB,
		ST_CNT,
		ST_SPANW,
		ST_SPANH,
		ST_DIVX,
		ST_DIVY,
		ST_DIVR,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/psc_alu.sv
// Shared add / subtract / compare unit.
`timescale 1ns / 1ps
module psc_alu
	import psc_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ALU_W-1:0] b_in;
	logic [ALU_W-1:0] sum;
	logic             cin;

	always_comb begin
		cin  = (req.op == ALU_SUB);
		b_in = cin ? ~req.b : req.b;
		sum  = req.a + b_in + {{(ALU_W-1){1'b0}}, cin};
		rsp.res = sum;
		rsp.neg = sum[ALU_W-1];
	end

endmodule

// File: rtl/psc_core.sv
// Sequencer and set state: drives the shared unit through the per-point and end-of-set steps.
`timescale 1ns / 1ps
module psc_core
	import psc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  in_item_t  item,
	output logic      idle,
	input  box_cfg_t  cfg,
	output alu_req_t  alu_req,
	input  alu_rsp_t  alu_rsp,
	input  logic      out_free,
	output logic      emit,
	output out_item_t result
);

	state_t state_q, state_d;

	logic signed [15:0] x_q, y_q;
	logic               last_q;
	logic signed [15:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [16:0]        sum_x_q, sum_y_q;
	logic [CNT_W-1:0]   cnt_q, cnt_out_q;
	logic               first_q, ovf_q, inside_q;
	logic [11:0]        edge_q;
	logic [15:0]        span_w_q, span_h_q;
	logic [10:0]        mean_x_q, mean_y_q;
	logic [8:0]         ratio_q;
	logic [5:0]         rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [STEP_W-1:0]  step_q;

	logic               accept, full, div_last;
	logic [CNT_W-1:0]   cnt_eff;
	logic [6:0]         shifted;
	logic [5:0]         rem_next;
	logic [DIV_W-1:0]   div_next;

	function automatic logic signed [ALU_W-1:0] sx16(input logic [15:0] v);
		return {{(ALU_W-16){v[15]}}, v};
	endfunction

	// whole-pixel part of a positive coordinate, zero otherwise
	function automatic logic [10:0] whole_pos(input logic [15:0] v);
		return v[15] ? 11'd0 : v[14:4];
	endfunction

	assign idle     = (state_q == ST_IDLE);
	assign accept   = idle && in_valid;
	assign cnt_eff  = first_q ? '0 : cnt_q;
	assign full     = (cnt_eff == CNT_W'(MAX_POINTS));
	assign div_last = (step_q == STEP_W'(DIV_W - 1));
	assign shifted  = {rem_q, div_q[DIV_W-1]};
	assign rem_next = alu_rsp.neg ? shifted[5:0] : alu_rsp.res[5:0];
	assign div_next = {div_q[DIV_W-2:0], ~alu_rsp.neg};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!full)
						state_d = ST_MINX;
					else if (item.last_point)
						state_d = ST_SPANW;
				end
			end
			ST_MINX:  state_d = ST_MAXX;
			ST_MAXX:  state_d = ST_MINY;
			ST_MINY:  state_d = ST_MAXY;
			ST_MAXY:  state_d = ST_SUMX;
			ST_SUMX:  state_d = ST_SUMY;
			ST_SUMY:  state_d = ST_BL;
			ST_BL:    state_d = ST_EDGX;
			ST_EDGX:  state_d = ST_BR;
			ST_BR:    state_d = ST_BT;
			ST_BT:    state_d = ST_EDGY;
			ST_EDGY:  state_d = ST_BB;
			ST_BB:    state_d = ST_CNT;
			ST_CNT:   state_d = last_q ? ST_SPANW : ST_IDLE;
			ST_SPANW: state_d = ST_SPANH;
			ST_SPANH: state_d = ST_DIVX;
			ST_DIVX:  if (div_last) state_d = ST_DIVY;
			ST_DIVY:  if (div_last) state_d = ST_DIVR;
			ST_DIVR:  if (div_last) state_d = ST_EMIT;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// shared unit operand select and result strobe
	always_comb begin
		alu_req.op = ALU_SUB;
		alu_req.a  = '0;
		alu_req.b  = '0;
		emit       = 1'b0;
		case (state_q)
			ST_MINX: begin
				alu_req.a = sx16(x_q);
				alu_req.b = sx16(min_x_q);
			end
			ST_MAXX: begin
				alu_req.a = sx16(max_x_q);
				alu_req.b = sx16(x_q);
			end
			ST_MINY: begin
				alu_req.a = sx16(y_q);
				alu_req.b = sx16(min_y_q);
			end
			ST_MAXY: begin
				alu_req.a = sx16(max_y_q);
				alu_req.b = sx16(y_q);
			end
			ST_SUMX: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(sum_x_q);
				alu_req.b  = ALU_W'(whole_pos(x_q));
			end
			ST_SUMY: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(sum_y_q);
				alu_req.b  = ALU_W'(whole_pos(y_q));
			end
			ST_BL: begin
				alu_req.a = ALU_W'({cfg.left, 4'b0});
				alu_req.b = sx16(x_q);
			end
			ST_EDGX: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(cfg.left);
				alu_req.b  = ALU_W'(cfg.width);
			end
			ST_BR: begin
				alu_req.a = sx16(x_q);
				alu_req.b = ALU_W'({edge_q, 4'b0});
			end
			ST_BT: begin
				alu_req.a = ALU_W'({cfg.top, 4'b0});
				alu_req.b = sx16(y_q);
			end
			ST_EDGY: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(cfg.top);
				alu_req.b  = ALU_W'(cfg.height);
			end
			ST_BB: begin
				alu_req.a = sx16(y_q);
				alu_req.b = ALU_W'({edge_q, 4'b0});
			end
			ST_SPANW: begin
				alu_req.a = sx16(max_x_q);
				alu_req.b = sx16(min_x_q);
			end
			ST_SPANH: begin
				alu_req.a = sx16(max_y_q);
				alu_req.b = sx16(min_y_q);
			end
			ST_DIVX, ST_DIVY, ST_DIVR: begin
				alu_req.a = ALU_W'(shifted);
				alu_req.b = ALU_W'(cnt_q);
			end
			ST_EMIT: emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			min_x_q   <= '0;
			max_x_q   <= '0;
			min_y_q   <= '0;
			max_y_q   <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			cnt_q     <= '0;
			cnt_out_q <= '0;
			first_q   <= 1'b1;
			ovf_q     <= 1'b0;
			step_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (first_q) begin
							min_x_q   <= item.pt_x;
							max_x_q   <= item.pt_x;
							min_y_q   <= item.pt_y;
							max_y_q   <= item.pt_y;
							sum_x_q   <= '0;
							sum_y_q   <= '0;
							cnt_q     <= '0;
							cnt_out_q <= '0;
							ovf_q     <= 1'b0;
							first_q   <= 1'b0;
						end
						if (full)
							ovf_q <= 1'b1;
					end
				end
				ST_MINX: if (alu_rsp.neg) min_x_q <= x_q;
				ST_MAXX: if (alu_rsp.neg) max_x_q <= x_q;
				ST_MINY: if (alu_rsp.neg) min_y_q <= y_q;
				ST_MAXY: if (alu_rsp.neg) max_y_q <= y_q;
				ST_SUMX: sum_x_q <= alu_rsp.res[16:0];
				ST_SUMY: sum_y_q <= alu_rsp.res[16:0];
				ST_CNT: begin
					cnt_q <= cnt_q + 1'b1;
					if (!inside_q)
						cnt_out_q <= cnt_out_q + 1'b1;
				end
				ST_SPANH: step_q <= '0;
				ST_DIVX, ST_DIVY, ST_DIVR: step_q <= div_last ? '0 : step_q + 1'b1;
				ST_EMIT: if (out_free) first_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q      <= item.pt_x;
					y_q      <= item.pt_y;
					last_q   <= item.last_point;
					inside_q <= 1'b1;
				end
			end
			ST_BL, ST_BR, ST_BT, ST_BB: inside_q <= inside_q & alu_rsp.neg;
			ST_EDGX, ST_EDGY: edge_q <= alu_rsp.res[11:0];
			ST_SPANW: span_w_q <= alu_rsp.res[15:0];
			ST_SPANH: begin
				span_h_q <= alu_rsp.res[15:0];
				div_q    <= sum_x_q;
				rem_q    <= '0;
			end
			ST_DIVX: begin
				rem_q <= div_last ? '0 : rem_next;
				div_q <= div_last ? sum_y_q : div_next;
				if (div_last)
					mean_x_q <= div_next[10:0];
			end
			ST_DIVY: begin
				rem_q <= div_last ? '0 : rem_next;
				div_q <= div_last ? DIV_W'({cnt_out_q, 8'b0}) : div_next;
				if (div_last)
					mean_y_q <= div_next[10:0];
			end
			ST_DIVR: begin
				rem_q <= rem_next;
				div_q <= div_next;
				if (div_last)
					ratio_q <= div_next[8:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		result.mean_x        = mean_x_q;
		result.mean_y        = mean_y_q;
		result.span_w        = span_w_q;
		result.span_h        = span_h_q;
		result.outside_count = cnt_out_q;
		result.point_count   = cnt_q;
		result.outside_ratio = ratio_q;
		result.overflow      = ovf_q;
	end

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_out_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |-> (cnt_out_q <= cnt_q))
		else $error("outside count above point count");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full) |=> (state_q == ST_MINX))
		else $error("accepted point did not start the update sequence");

	a_emit_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (!first_q && cnt_q != '0))
		else $error("result emitted without an open set");

	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVX || state_q == ST_DIVY || state_q == ST_DIVR)
			|-> (step_q <= STEP_W'(DIV_W - 1)))
		else $error("divider step count out of range");

endmodule

// File: rtl/point_set_centroid_bbox_outlier.sv
// Top level: configuration registers, sequencer, shared unit and result register.
`timescale 1ns / 1ps
// Summarizes a set of feature points (signed Q12.4) given one per transaction, the set
// ending at a transaction with last_point set. Per set it reports the truncated means of
// the whole-pixel parts of the positive coordinates, the x and y spans, the number of
// points not strictly inside the configured box (edges count as outside), that number
// in 1/256 of the point count, and an overflow flag when more than MAX_POINTS (32)
// points arrived; extra points are dropped but a dropped last point still closes the
// set. All arithmetic runs through one shared 20-bit add/subtract unit stepped by the
// sequencer, so in_stall is high while a point is being worked on: an accepted point
// goes through an accept, twelve unit steps and a count update; a point beyond
// capacity is dropped as it is accepted. A last point adds 2 span steps, three 17-step
// restoring divides (mean x, mean y, ratio) and an emit step that hands the result to
// the output register once it is free. The result register lets the next set start
// while a result waits on out_stall; only a second result has to wait for the first to
// be taken. Box registers are written through the cfg port (always ready) and must be
// changed only while idle.
module point_set_centroid_bbox_outlier
	import psc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// point input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	// result output
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [10:0]          cfg_data
);

	box_cfg_t  cfg_q;
	alu_req_t  alu_req;
	alu_rsp_t  alu_rsp;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;
	logic      idle, emit, out_free;

	assign cfg_ready = 1'b1;

	// box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOX_LEFT:   cfg_q.left   <= cfg_data;
				REG_BOX_TOP:    cfg_q.top    <= cfg_data;
				REG_BOX_WIDTH:  cfg_q.width  <= cfg_data;
				REG_BOX_HEIGHT: cfg_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	psc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (in_data),
		.idle     (idle),
		.cfg      (cfg_q),
		.alu_req  (alu_req),
		.alu_rsp  (alu_rsp),
		.out_free (out_free),
		.emit     (emit),
		.result   (result)
	);

	psc_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign in_stall = !idle;

	// result register: free when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
